/* rtl/core/pfb_pkg.sv */
// Shared types and codes for the page framebuffer pixel plotter.
package pfb_pkg;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_CALC   = 4'b0100,
        ST_MODIFY = 4'b1000
    } t_state;

    // Item commands.
    localparam logic CMD_PLOT = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Pixel colors.
    localparam logic [1:0] COLOR_CLEAR  = 2'd0;
    localparam logic [1:0] COLOR_SET    = 2'd1;
    localparam logic [1:0] COLOR_TOGGLE = 2'd2;
    localparam logic [1:0] COLOR_KEEP   = 2'd3;

    // Rotation modes.
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ROTATION     = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] RST_PANEL_WIDTH  = 8'd128;
    localparam logic [6:0] RST_PANEL_HEIGHT = 7'd64;

endpackage

/* rtl/core/pfb_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pixel_framebuffer_plot.sv */
// Top level of the page-organized monochrome framebuffer pixel plotter.
//
// One bit per pixel; byte (column + page * width) holds rows 8*page..8*page+7
// of one column, row r in bit r mod 8. An item is taken when start is high and
// busy is low. A plot word checks signed (x, y) against the logical size
// (width and height swap under rotations of 90 and 270 degrees), maps it onto
// the panel and does a read-modify-write of the addressed byte; a read word
// returns one stored byte (zero past the end of the store). Each item yields
// exactly one result word, shown for a single cycle with o_valid high; the
// receiver cannot stall, so results must be taken as they appear. An item
// goes through the address stage and the write-back, its result registered
// from the write-back; a new item can be accepted during the previous one's
// write-back, as the store read is registered ahead of it. After reset the
// store is swept to zero one byte per cycle, MAX_WIDTH * ceil(MAX_HEIGHT / 8)
// bytes (1024 at the defaults), with busy high; configuration writes are
// taken at any time and should only be issued while no item is in flight.
module pixel_framebuffer_plot #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [1:0]  i_pixel_color,
    input  logic [9:0]  i_read_index,
    // result channel
    output logic        o_valid,
    output logic [7:0]  o_read_data,
    output logic        o_pixel_drawn,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int STORE_DEPTH = MAX_WIDTH * ((MAX_HEIGHT + 7) / 8);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int SW = AW + 1;                 // address math headroom
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // configuration
    logic [7:0] r_panel_width;
    logic [6:0] r_panel_height;
    logic [1:0] r_rotation_mode;

    // control
    pfb_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr_addr;

    // captured item
    logic        r_cmd;
    logic [15:0] r_pos_x;
    logic [15:0] r_pos_y;
    logic [1:0]  r_color;
    logic [9:0]  r_read_index;

    // modify stage
    logic          r_m_cmd;
    logic          r_m_hit;       // plot in bounds, or read inside the store
    logic [1:0]    r_m_color;
    logic [7:0]    r_m_mask;
    logic [AW-1:0] r_m_addr;

    // result word
    logic       r_valid;
    logic [7:0] r_read_data;
    logic       r_pixel_drawn;

    // address unit
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [15:0]   w16, h16, lw16, lh16, px16, py16;
    logic          in_bounds;
    logic          read_ok;
    logic [SW-1:0] plot_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    mask;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic [7:0]    mod_byte;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_width   <= pfb_pkg::RST_PANEL_WIDTH;
            r_panel_height  <= pfb_pkg::RST_PANEL_HEIGHT;
            r_rotation_mode <= pfb_pkg::ROT_0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pfb_pkg::CFG_PANEL_WIDTH:  r_panel_width   <= i_cfg_data;
                pfb_pkg::CFG_PANEL_HEIGHT: r_panel_height  <= i_cfg_data[6:0];
                pfb_pkg::CFG_ROTATION:     r_rotation_mode <= i_cfg_data[1:0];
                default: ;                  // unmapped index, ignored
            endcase
        end
    end

    // Free to take an item when idle, or while the previous one writes back:
    // its write lands before the next read is issued.
    assign busy = !(r_state == pfb_pkg::ST_IDLE || r_state == pfb_pkg::ST_MODIFY);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfb_pkg::ST_CLEAR: begin
                if (r_clr_addr == AW'(STORE_DEPTH - 1)) begin
                    n_state = pfb_pkg::ST_IDLE;
                end
            end
            pfb_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = pfb_pkg::ST_CALC;
                end
            end
            pfb_pkg::ST_CALC: n_state = pfb_pkg::ST_MODIFY;
            pfb_pkg::ST_MODIFY: begin
                n_state = start ? pfb_pkg::ST_CALC : pfb_pkg::ST_IDLE;
            end
            default: n_state = pfb_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pfb_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == pfb_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // capture the item word
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd        <= i_cmd;
            r_pos_x      <= i_pos_x;
            r_pos_y      <= i_pos_y;
            r_color      <= i_pixel_color;
            r_read_index <= i_read_index;
        end
    end

    // Effective panel size, clamped to the store geometry.
    assign w_eff = (16'(r_panel_width) > 16'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(r_panel_width);
    assign h_eff = (16'(r_panel_height) > 16'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                            : HW'(r_panel_height);
    assign w16 = 16'(w_eff);
    assign h16 = 16'(h_eff);

    // Logical bounds swap on quarter turns.
    assign lw16 = r_rotation_mode[0] ? h16 : w16;
    assign lh16 = r_rotation_mode[0] ? w16 : h16;

    assign in_bounds = !r_pos_x[15] && !r_pos_y[15] && (r_pos_x < lw16) && (r_pos_y < lh16);

    always_comb begin
        unique case (r_rotation_mode)
            pfb_pkg::ROT_90: begin
                px16 = w16 - 16'd1 - r_pos_y;
                py16 = r_pos_x;
            end
            pfb_pkg::ROT_180: begin
                px16 = w16 - 16'd1 - r_pos_x;
                py16 = h16 - 16'd1 - r_pos_y;
            end
            pfb_pkg::ROT_270: begin
                px16 = r_pos_y;
                py16 = h16 - 16'd1 - r_pos_x;
            end
            default: begin
                px16 = r_pos_x;
                py16 = r_pos_y;
            end
        endcase
    end

    // byte = column + page * width; page is row / 8
    assign plot_addr = SW'(px16) + SW'(py16[15:3]) * SW'(w16);
    assign mask      = 8'd1 << py16[2:0];
    assign read_ok   = 32'(r_read_index) < 32'(STORE_DEPTH);
    assign rd_addr   = (r_cmd == pfb_pkg::CMD_READ) ? AW'(r_read_index) : plot_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == pfb_pkg::ST_CALC) begin
            r_m_cmd   <= r_cmd;
            r_m_hit   <= (r_cmd == pfb_pkg::CMD_READ) ? read_ok : in_bounds;
            r_m_color <= r_color;
            r_m_mask  <= mask;
            r_m_addr  <= plot_addr[AW-1:0];
        end
    end

    always_comb begin
        unique case (r_m_color)
            pfb_pkg::COLOR_CLEAR:  mod_byte = ram_rdata & ~r_m_mask;
            pfb_pkg::COLOR_SET:    mod_byte = ram_rdata | r_m_mask;
            pfb_pkg::COLOR_TOGGLE: mod_byte = ram_rdata ^ r_m_mask;
            default:               mod_byte = ram_rdata;
        endcase
    end

    // Write port: reset sweep, else the plot write-back.
    always_comb begin
        if (r_state == pfb_pkg::ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == pfb_pkg::ST_MODIFY) && (r_m_cmd == pfb_pkg::CMD_PLOT)
                        && r_m_hit && (r_m_color != pfb_pkg::COLOR_KEEP);
            ram_waddr = r_m_addr;
            ram_wdata = mod_byte;
        end
    end

    pfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == pfb_pkg::ST_MODIFY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pfb_pkg::ST_MODIFY) begin
            r_read_data   <= (r_m_cmd == pfb_pkg::CMD_READ && r_m_hit) ? ram_rdata : 8'd0;
            r_pixel_drawn <= (r_m_cmd == pfb_pkg::CMD_PLOT) && r_m_hit;
        end
    end

    assign o_valid       = r_valid;
    assign o_read_data   = r_read_data;
    assign o_pixel_drawn = r_pixel_drawn;

`ifndef SYNTHESIS
    a_valid_after_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == pfb_pkg::ST_MODIFY))
        else $error("result without write-back cycle");

    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy) |=> (r_state == pfb_pkg::ST_CALC))
        else $error("accepted item did not enter address stage");

    a_no_write_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfb_pkg::ST_CALC || r_state == pfb_pkg::ST_IDLE) |-> !ram_we)
        else $error("store written outside clear or write-back");

    a_plot_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_pixel_drawn) |-> (r_read_data == 8'd0))
        else $error("plot result carries read data");

    a_busy_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfb_pkg::ST_CLEAR) |-> (busy && ram_we))
        else $error("clear sweep not holding off items");
`endif

endmodule

/* verif/pixel_framebuffer_plot_tb.sv */
// Self-checking testbench for pixel_framebuffer_plot: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module pixel_framebuffer_plot_tb;
    import pfb_pkg::*;

    localparam int MAX_W           = 128;
    localparam int MAX_H           = 64;
    localparam int STORE_BYTES     = MAX_W * ((MAX_H + 7) / 8);
    localparam int N_DIRECTED      = 23;
    localparam int N_PHASES        = 13;
    localparam int WORDS_PER_PHASE = 125;
    // index 3 maps to no register; writes there must be ignored
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       drawn;
    } pix_result_t;

    // one row of the directed table; known marks a typed-in expectation
    typedef struct packed {
        logic       cmd;
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0] color;
        logic [9:0] ridx;
        logic       known;
        logic [7:0] exp_data;
        logic       exp_drawn;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cmd;
    logic [15:0] i_pos_x;
    logic [15:0] i_pos_y;
    logic [1:0]  i_pixel_color;
    logic [9:0]  i_read_index;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic        o_pixel_drawn;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    // typed-in expectation travels with the word it belongs to
    logic        row_known;
    logic [7:0]  row_exp_data;
    logic        row_exp_drawn;

    // shadow copy of the block: frame bytes and panel registers
    logic [7:0]  shadow_fb [0:STORE_BYTES-1];
    logic [7:0]  shadow_width;
    logic [6:0]  shadow_height;
    logic [1:0]  shadow_rot;

    pix_result_t pending_results [$];
    int          err_count = 0;
    stim_row_t   directed_rows [0:N_DIRECTED-1];

    pixel_framebuffer_plot #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pixel_color (i_pixel_color),
        .i_read_index  (i_read_index),
        .o_valid       (o_valid),
        .o_read_data   (o_read_data),
        .o_pixel_drawn (o_pixel_drawn),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Applies one word to the shadow framebuffer and returns the result it yields.
    function automatic pix_result_t apply_pixel_word(logic cmd, logic [15:0] raw_x,
                                                     logic [15:0] raw_y, logic [1:0] color,
                                                     logic [9:0] ridx);
        int          w;
        int          h;
        int          lw;
        int          lh;
        int          xs;
        int          ys;
        int          px;
        int          py;
        int          addr;
        logic [7:0]  mask;
        pix_result_t r;
        r = '0;
        // oversized settings clamp to the store's geometry
        w = shadow_width;
        if (w > MAX_W) w = MAX_W;
        h = shadow_height;
        if (h > MAX_H) h = MAX_H;
        if (cmd == CMD_READ) begin
            if (ridx < STORE_BYTES) r.data = shadow_fb[ridx];
            return r;
        end
        // logical size swaps under quarter turns
        if (shadow_rot == ROT_90 || shadow_rot == ROT_270) begin
            lw = h;
            lh = w;
        end else begin
            lw = w;
            lh = h;
        end
        xs = $signed(raw_x);
        ys = $signed(raw_y);
        if (xs < 0 || xs >= lw || ys < 0 || ys >= lh) return r;
        case (shadow_rot)
            ROT_90: begin
                px = w - 1 - ys;
                py = xs;
            end
            ROT_180: begin
                px = w - 1 - xs;
                py = h - 1 - ys;
            end
            ROT_270: begin
                px = ys;
                py = h - 1 - xs;
            end
            default: begin
                px = xs;
                py = ys;
            end
        endcase
        addr = px + (py / 8) * w;
        if (addr < STORE_BYTES) begin
            mask = 8'd1 << (py % 8);
            case (color)
                COLOR_CLEAR:  shadow_fb[addr] = shadow_fb[addr] & ~mask;
                COLOR_SET:    shadow_fb[addr] = shadow_fb[addr] | mask;
                COLOR_TOGGLE: shadow_fb[addr] = shadow_fb[addr] ^ mask;
                default: ;
            endcase
        end
        r.drawn = 1'b1;
        return r;
    endfunction

    // Scoreboard: checks result words, tracks register writes, predicts accepted words.
    // Everything is sampled at the rising edge, before the edge's updates land.
    always @(posedge i_clk) begin
        pix_result_t want;
        pix_result_t calc;
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_BYTES; k++) shadow_fb[k] = 8'h00;
            shadow_width  = RST_PANEL_WIDTH;
            shadow_height = RST_PANEL_HEIGHT;
            shadow_rot    = ROT_0;
            pending_results.delete();
        end else begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result word with none expected: read_data %02h drawn %0b",
                             $time, o_read_data, o_pixel_drawn);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_read_data !== want.data) begin
                        $display("%0t: read_data expected %02h actual %02h",
                                 $time, want.data, o_read_data);
                        err_count++;
                    end
                    if (o_pixel_drawn !== want.drawn) begin
                        $display("%0t: pixel_drawn expected %0b actual %0b",
                                 $time, want.drawn, o_pixel_drawn);
                        err_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PANEL_WIDTH:  shadow_width  = i_cfg_data;
                    CFG_PANEL_HEIGHT: shadow_height = i_cfg_data[6:0];
                    CFG_ROTATION:     shadow_rot    = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                // state always advances; a typed-in value overrides the prediction
                calc = apply_pixel_word(i_cmd, i_pos_x, i_pos_y, i_pixel_color, i_read_index);
                if (row_known) calc = {row_exp_data, row_exp_drawn};
                pending_results.push_back(calc);
            end
        end
    end

    // Mostly short gaps, now and then a long one; quiet phases run back to back.
    function automatic int pick_gap(bit quiet);
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Presents one word after an idle gap and returns at the edge that takes it.
    // start is left high so the next word can follow with no bubble.
    task automatic send_word(logic cmd, logic [15:0] x, logic [15:0] y, logic [1:0] color,
                             logic [9:0] ridx, logic known, logic [7:0] k_data,
                             logic k_drawn, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_pixel_color <= color;
        i_read_index  <= ridx;
        row_known     <= known;
        row_exp_data  <= k_data;
        row_exp_drawn <= k_drawn;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Stops issuing and waits until every expected word has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // One register write; valid stays high for back-to-back writes.
    task automatic cfg_word(logic [1:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Full panel setup; junk in the unused upper bits and a write to the spare index.
    task automatic write_panel(logic [7:0] w, logic [7:0] h, logic [1:0] rot);
        cfg_word(CFG_PANEL_WIDTH, w);
        cfg_word(CFG_PANEL_HEIGHT, h);
        cfg_word(CFG_ROTATION, {6'($urandom()), rot});
        cfg_word(CFG_SPARE, 8'($urandom()));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        stim_row_t  row;
        logic [7:0] cfg_w;
        logic [7:0] cfg_h;
        logic [1:0] cfg_rot;
        int         eff_w;
        int         eff_h;
        int         lw;
        int         lh;
        int         area;
        int         roll;
        bit         quiet;
        logic [15:0] x;
        logic [15:0] y;
        logic [9:0] ridx;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_cmd         <= CMD_PLOT;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_pixel_color <= COLOR_CLEAR;
        i_read_index  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_PANEL_WIDTH;
        i_cfg_data    <= '0;
        row_known     <= 1'b0;
        row_exp_data  <= '0;
        row_exp_drawn <= 1'b0;

        // Directed part at the reset panel: 128 x 64, no rotation.
        directed_rows = '{
            // store reads back as zero after the reset sweep
            '{CMD_READ, 16'd0, 16'd0, COLOR_CLEAR, 10'd0, 1'b1, 8'h00, 1'b0},
            '{CMD_READ, 16'd0, 16'd0, COLOR_CLEAR, 10'd1023, 1'b1, 8'h00, 1'b0},
            // opposite corners of the panel
            '{CMD_PLOT, 16'd0, 16'd0, COLOR_SET, 10'd0, 1'b1, 8'h00, 1'b1},
            '{CMD_READ, 16'd0, 16'd0, COLOR_CLEAR, 10'd0, 1'b0, 8'h00, 1'b0},
            '{CMD_PLOT, 16'd127, 16'd63, COLOR_SET, 10'd1023, 1'b1, 8'h00, 1'b1},
            // coordinates of a read word are don't-care
            '{CMD_READ, 16'hFFFF, 16'hFFFF, COLOR_KEEP, 10'd1023, 1'b0, 8'h00, 1'b0},
            // just past each edge, then the extremes of the signed range
            '{CMD_PLOT, 16'd128, 16'd0, COLOR_SET, 10'd0, 1'b1, 8'h00, 1'b0},
            '{CMD_PLOT, 16'd0, 16'd64, COLOR_SET, 10'd0, 1'b1, 8'h00, 1'b0},
            '{CMD_PLOT, 16'hFFFF, 16'd0, COLOR_SET, 10'd0, 1'b1, 8'h00, 1'b0},
            '{CMD_PLOT, 16'd0, 16'hFFFF, COLOR_TOGGLE, 10'd0, 1'b1, 8'h00, 1'b0},
            '{CMD_PLOT, 16'h8000, 16'h7FFF, COLOR_SET, 10'd0, 1'b1, 8'h00, 1'b0},
            '{CMD_PLOT, 16'h7FFF, 16'h8000, COLOR_CLEAR, 10'd0, 1'b1, 8'h00, 1'b0},
            // toggle twice, keep color, clear
            '{CMD_PLOT, 16'd0, 16'd0, COLOR_TOGGLE, 10'd0, 1'b0, 8'h00, 1'b0},
            '{CMD_READ, 16'd0, 16'd0, COLOR_CLEAR, 10'd0, 1'b0, 8'h00, 1'b0},
            '{CMD_PLOT, 16'd0, 16'd0, COLOR_TOGGLE, 10'd0, 1'b0, 8'h00, 1'b0},
            '{CMD_PLOT, 16'd0, 16'd1, COLOR_KEEP, 10'h3FF, 1'b1, 8'h00, 1'b1},
            '{CMD_READ, 16'd0, 16'd0, COLOR_CLEAR, 10'd0, 1'b0, 8'h00, 1'b0},
            '{CMD_PLOT, 16'd0, 16'd0, COLOR_CLEAR, 10'd0, 1'b0, 8'h00, 1'b0},
            '{CMD_READ, 16'd0, 16'd0, COLOR_CLEAR, 10'd0, 1'b0, 8'h00, 1'b0},
            // second page of column 5
            '{CMD_PLOT, 16'd5, 16'd13, COLOR_SET, 10'd0, 1'b0, 8'h00, 1'b0},
            '{CMD_READ, 16'd0, 16'd0, COLOR_CLEAR, 10'd133, 1'b0, 8'h00, 1'b0},
            '{CMD_PLOT, 16'd127, 16'd63, COLOR_CLEAR, 10'd0, 1'b0, 8'h00, 1'b0},
            '{CMD_READ, 16'd0, 16'd0, COLOR_CLEAR, 10'd1023, 1'b0, 8'h00, 1'b0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // block sweeps its store with busy high; the first word waits on that
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            send_word(row.cmd, row.x, row.y, row.color, row.ridx, row.known,
                      row.exp_data, row.exp_drawn, pick_gap(1'b0));
        end

        // Random phases, each under its own panel setting.
        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            case (p)
                0:  begin cfg_w = 8'd128; cfg_h = 8'd64;  cfg_rot = ROT_90;  end
                1:  begin cfg_w = 8'd128; cfg_h = 8'd64;  cfg_rot = ROT_180; end
                2:  begin cfg_w = 8'd128; cfg_h = 8'd64;  cfg_rot = ROT_270; end
                // oversized: both clamp to the store geometry
                3:  begin cfg_w = 8'd255; cfg_h = 8'd255; cfg_rot = ROT_0;   end
                // zero width, then zero height: nothing may be drawn
                4:  begin cfg_w = 8'd0;   cfg_h = 8'd64;  cfg_rot = ROT_0;   end
                5:  begin cfg_w = 8'd128; cfg_h = 8'd0;   cfg_rot = ROT_90;  end
                // single-pixel panel
                6:  begin cfg_w = 8'd1;   cfg_h = 8'd1;   cfg_rot = ROT_270; end
                default: begin
                    cfg_w   = 8'($urandom_range(1, 255));
                    cfg_h   = 8'($urandom());
                    cfg_rot = 2'($urandom());
                end
            endcase
            write_panel(cfg_w, cfg_h, cfg_rot);

            eff_w = (cfg_w > MAX_W) ? MAX_W : cfg_w;
            eff_h = (cfg_h[6:0] > MAX_H) ? MAX_H : cfg_h[6:0];
            if (cfg_rot == ROT_90 || cfg_rot == ROT_270) begin
                lw = eff_h;
                lh = eff_w;
            end else begin
                lw = eff_w;
                lh = eff_h;
            end
            area  = eff_w * ((eff_h + 7) / 8);
            quiet = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 99);
                // mostly coordinates in and just around the panel
                if (roll < 10) begin
                    x = 16'($urandom());
                    y = 16'($urandom());
                end else begin
                    x = 16'($urandom_range(0, lw + 1) - 1);
                    y = 16'($urandom_range(0, lh + 1) - 1);
                end
                if (area > 0 && $urandom_range(0, 4) != 0)
                    ridx = 10'($urandom_range(0, area - 1));
                else
                    ridx = 10'($urandom());
                send_word((roll < 65) ? CMD_PLOT : CMD_READ, x, y, 2'($urandom()), ridx,
                          1'b0, 8'h00, 1'b0, pick_gap(quiet));
            end
        end

        drain_results();
        // keep clocking after the drain to catch strays
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
